[sv/ttb_pkg.sv]
// shared constants and types for the triangle tangent unit
package ttb_pkg;
   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int IN_INDEX_W = 16;
   localparam int IN_COORD_W = 16;
   localparam int OUT_VEC_W = 32;
   localparam int FRAC_STEPS = 20;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;
endpackage

[sv/ttb_if.sv]
// valid/ready channel interfaces for vertex input and result output
interface ttb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] vertex_index;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] tex_u;
   logic signed [15:0] tex_v;
   modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                   input ready);
   modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                 output ready);
endinterface

interface ttb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_index;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;
   logic signed [31:0] bitangent_x;
   logic signed [31:0] bitangent_y;
   logic signed [31:0] bitangent_z;
   logic        degenerate;
   logic        last;
   modport source (output valid, out_index, tangent_x, tangent_y, tangent_z,
                   bitangent_x, bitangent_y, bitangent_z, degenerate, last,
                   input ready);
   modport sink (input valid, out_index, tangent_x, tangent_y, tangent_z,
                 bitangent_x, bitangent_y, bitangent_z, degenerate, last,
                 output ready);
endinterface

[sv/ttb_front.sv]
// front end: holds corners, forms numerators and determinant, pushes triangles into a queue
module ttb_front #(
   parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEFAULT,
   parameter int COORD_BITS = ttb_pkg::COORD_BITS_DEFAULT,
   parameter int NUM_W = 2 * COORD_BITS + 4,
   parameter int TRI_W = 3 * INDEX_BITS + 7 * NUM_W
) (
   input  logic             clock,
   input  logic             reset,
   ttb_req_if.sink          req,
   output logic             q_valid,
   input  logic             q_ready,
   output logic [TRI_W-1:0] q_data
);
   localparam int DW = COORD_BITS + 1;
   localparam int QD = ttb_pkg::QUEUE_DEPTH;

   logic [1:0] count_ff, count_in;
   logic [INDEX_BITS-1:0] hidx_ff [2];
   logic signed [COORD_BITS-1:0] hpos_ff [2][3];
   logic signed [COORD_BITS-1:0] htex_ff [2][2];

   // stage 1 registers: deltas
   logic s1_ff, s1_in;
   logic [3*INDEX_BITS-1:0] s1_idx_ff;
   logic signed [DW-1:0] e0_ff [3], e1_ff [3];
   logic signed [DW-1:0] du0_ff, dv0_ff, du1_ff, dv1_ff;
   // stage 2 registers: products
   logic s2_ff;
   logic [3*INDEX_BITS-1:0] s2_idx_ff;
   logic signed [2*DW-1:0] pa_ff [3], pb_ff [3], pc_ff [3], pd_ff [3];
   logic signed [2*DW-1:0] pe_ff, pf_ff;
   // stage 3: packed triangle into queue
   logic s3_ff;
   logic [TRI_W-1:0] s3_data_ff, s3_data_in;

   logic [TRI_W-1:0] q_mem_ff [QD];
   logic [$clog2(QD+1)-1:0] q_cnt_ff;
   logic q_rd_ff, q_wr_ff;
   logic [$clog2(QD+1)-1:0] inflight;
   logic take, pop;
   logic signed [COORD_BITS-1:0] p [3], t [2];

   assign inflight = q_cnt_ff + {{($clog2(QD+1)-1){1'b0}}, s1_ff}
      + {{($clog2(QD+1)-1){1'b0}}, s2_ff} + {{($clog2(QD+1)-1){1'b0}}, s3_ff};
   // third corner only when a queue slot is guaranteed
   assign req.ready = (count_ff != 2'd2) || (inflight < ($clog2(QD+1))'(QD));
   assign take = req.valid && req.ready;
   assign s1_in = take && (count_ff == 2'd2);
   assign count_in = take ? ((count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1) : count_ff;

   assign p[0] = req.pos_x[COORD_BITS-1:0];
   assign p[1] = req.pos_y[COORD_BITS-1:0];
   assign p[2] = req.pos_z[COORD_BITS-1:0];
   assign t[0] = req.tex_u[COORD_BITS-1:0];
   assign t[1] = req.tex_v[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take && count_ff != 2'd2) begin
         hidx_ff[count_ff[0]] <= req.vertex_index[INDEX_BITS-1:0];
         for (int j = 0; j < 3; j++) hpos_ff[count_ff[0]][j] <= p[j];
         for (int j = 0; j < 2; j++) htex_ff[count_ff[0]][j] <= t[j];
      end
      if (s1_in) begin
         s1_idx_ff <= {req.vertex_index[INDEX_BITS-1:0], hidx_ff[1], hidx_ff[0]};
         for (int j = 0; j < 3; j++) begin
            e0_ff[j] <= DW'(hpos_ff[1][j]) - DW'(hpos_ff[0][j]);
            e1_ff[j] <= DW'(p[j]) - DW'(hpos_ff[0][j]);
         end
         du0_ff <= DW'(htex_ff[1][0]) - DW'(htex_ff[0][0]);
         dv0_ff <= DW'(htex_ff[1][1]) - DW'(htex_ff[0][1]);
         du1_ff <= DW'(t[0]) - DW'(htex_ff[0][0]);
         dv1_ff <= DW'(t[1]) - DW'(htex_ff[0][1]);
      end
      if (s1_ff) begin
         s2_idx_ff <= s1_idx_ff;
         for (int j = 0; j < 3; j++) begin
            pa_ff[j] <= e0_ff[j] * dv1_ff;
            pb_ff[j] <= e1_ff[j] * dv0_ff;
            pc_ff[j] <= e1_ff[j] * du0_ff;
            pd_ff[j] <= e0_ff[j] * du1_ff;
         end
         pe_ff <= du0_ff * dv1_ff;
         pf_ff <= dv0_ff * du1_ff;
      end
      if (s2_ff) s3_data_ff <= s3_data_in;
   end

   always_comb begin
      s3_data_in = '0;
      s3_data_in[3*INDEX_BITS-1:0] = s2_idx_ff;
      for (int j = 0; j < 3; j++) begin
         s3_data_in[3*INDEX_BITS + j*NUM_W +: NUM_W] = NUM_W'(pa_ff[j]) - NUM_W'(pb_ff[j]);
         s3_data_in[3*INDEX_BITS + (3+j)*NUM_W +: NUM_W] =
            NUM_W'(pc_ff[j]) - NUM_W'(pd_ff[j]);
      end
      s3_data_in[3*INDEX_BITS + 6*NUM_W +: NUM_W] = NUM_W'(pe_ff) - NUM_W'(pf_ff);
   end

   // small queue between front and back
   assign pop = q_valid && q_ready;
   assign q_valid = q_cnt_ff != '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_rd_ff <= 1'b0;
         q_wr_ff <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_ff + {{($clog2(QD+1)-1){1'b0}}, s3_ff}
            - {{($clog2(QD+1)-1){1'b0}}, pop};
         if (s3_ff) q_wr_ff <= ~q_wr_ff;
         if (pop) q_rd_ff <= ~q_rd_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (s3_ff) q_mem_ff[q_wr_ff] <= s3_data_ff;
   end
   assign q_data = q_mem_ff[q_rd_ff];
endmodule

[sv/ttb_back.sv]
// back end: shared serial divider and emission of three corner results
module ttb_back #(
   parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEFAULT,
   parameter int COORD_BITS = ttb_pkg::COORD_BITS_DEFAULT,
   parameter int NUM_W = 2 * COORD_BITS + 4,
   parameter int TRI_W = 3 * INDEX_BITS + 7 * NUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  logic [TRI_W-1:0] q_data,
   ttb_rsp_if.source        rsp
);
   localparam int VW = ttb_pkg::OUT_VEC_W;
   localparam int FS = ttb_pkg::FRAC_STEPS;
   // quotient bits: integer part up to NUM_W plus FS+1 fraction bits
   localparam int QB = NUM_W + FS + 1;
   localparam int RW = NUM_W + 1;
   localparam int SW = $clog2(QB + 1);

   ttb_pkg::back_state_type state_ff, state_in;
   logic [3*INDEX_BITS-1:0] idx_ff;
   logic [NUM_W-1:0] num_ff [6];
   logic [NUM_W-1:0] dmag_ff;
   logic dneg_ff, degen_ff;
   logic [2:0] comp_ff;
   logic [SW-1:0] step_ff;
   logic [QB-1:0] quo_ff;
   logic [RW-1:0] rem_ff;
   logic [QB-1:0] nsh_ff;
   logic nneg_ff;
   logic [VW-1:0] res_ff [6];
   logic [1:0] corner_ff;
   logic [NUM_W-1:0] cur_num;
   logic [NUM_W-1:0] cur_mag;
   logic [RW-1:0] rem_sh;
   logic rem_ge;
   logic [QB-1:0] rounded;
   logic [VW-1:0] sat;
   logic start, comp_done, emit_pop;

   assign cur_num = num_ff[comp_ff];
   // magnitude at numerator width, before widening
   assign cur_mag = cur_num[NUM_W-1] ? -cur_num : cur_num;
   assign rem_sh = {rem_ff[RW-2:0], nsh_ff[QB-1]};
   assign rem_ge = rem_sh >= RW'(dmag_ff);
   // quotient has one extra fraction bit for rounding
   assign rounded = (quo_ff >> 1) + QB'(quo_ff[0]);

   always_comb begin
      logic big;
      big = (rounded >> (VW - 1)) != '0;
      if (nneg_ff) sat = big ? ((rounded == (QB'(1) << (VW - 1))) ? rounded[VW-1:0] : {1'b1,
         {(VW-1){1'b0}}}) : VW'(-rounded[VW-1:0]);
      else sat = big ? {1'b0, {(VW-1){1'b1}}} : rounded[VW-1:0];
      if (nneg_ff && rounded == (QB'(1) << (VW - 1))) sat = {1'b1, {(VW-1){1'b0}}};
   end

   assign start = (state_ff == ttb_pkg::BK_IDLE) && q_valid;
   assign comp_done = (state_ff == ttb_pkg::BK_DIVIDE) && (step_ff == SW'(QB));
   assign emit_pop = rsp.valid && rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttb_pkg::BK_IDLE:   if (q_valid) state_in = ttb_pkg::BK_DIVIDE;
         ttb_pkg::BK_DIVIDE: if (degen_ff || (comp_done && comp_ff == 3'd5))
            state_in = ttb_pkg::BK_EMIT;
         ttb_pkg::BK_EMIT:   if (emit_pop && corner_ff == 2'd2) state_in = ttb_pkg::BK_IDLE;
         default:            state_in = ttb_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ttb_pkg::BK_IDLE:   q_ready = 1'b1;
         ttb_pkg::BK_DIVIDE: ;
         ttb_pkg::BK_EMIT:   rsp.valid = 1'b1;
         default:            ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttb_pkg::BK_IDLE;
         corner_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (start) corner_ff <= 2'd0;
         else if (emit_pop) corner_ff <= corner_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      logic [NUM_W-1:0] det;
      det = q_data[3*INDEX_BITS + 6*NUM_W +: NUM_W];
      if (start) begin
         idx_ff <= q_data[3*INDEX_BITS-1:0];
         for (int j = 0; j < 6; j++) num_ff[j] <= q_data[3*INDEX_BITS + j*NUM_W +: NUM_W];
         dneg_ff <= det[NUM_W-1];
         dmag_ff <= det[NUM_W-1] ? -det : det;
         degen_ff <= det == '0;
         comp_ff <= 3'd0;
         step_ff <= '1;
         for (int j = 0; j < 6; j++) res_ff[j] <= '0;
      end else if (state_ff == ttb_pkg::BK_DIVIDE && !degen_ff) begin
         if (step_ff == '1) begin
            // load current numerator magnitude, shifted for fraction bits
            nneg_ff <= cur_num[NUM_W-1] ^ dneg_ff;
            nsh_ff <= QB'(cur_mag) << (FS + 1);
            rem_ff <= '0;
            quo_ff <= '0;
            step_ff <= '0;
         end else if (comp_done) begin
            res_ff[comp_ff] <= sat;
            comp_ff <= comp_ff + 3'd1;
            step_ff <= '1;
         end else begin
            rem_ff <= rem_ge ? rem_sh - RW'(dmag_ff) : rem_sh;
            quo_ff <= {quo_ff[QB-2:0], rem_ge};
            nsh_ff <= nsh_ff << 1;
            step_ff <= step_ff + SW'(1);
         end
      end
   end

   always_comb begin
      unique case (corner_ff)
         2'd0:    rsp.out_index = 16'(idx_ff[0 +: INDEX_BITS]);
         2'd1:    rsp.out_index = 16'(idx_ff[INDEX_BITS +: INDEX_BITS]);
         default: rsp.out_index = 16'(idx_ff[2*INDEX_BITS +: INDEX_BITS]);
      endcase
   end
   assign rsp.tangent_x = res_ff[0];
   assign rsp.tangent_y = res_ff[1];
   assign rsp.tangent_z = res_ff[2];
   assign rsp.bitangent_x = res_ff[3];
   assign rsp.bitangent_y = res_ff[4];
   assign rsp.bitangent_z = res_ff[5];
   assign rsp.degenerate = degen_ff;
   assign rsp.last = corner_ff == 2'd2;
endmodule

[sv/triangle_tangent_bitangent.sv]
// top level of the triangle tangent and bitangent unit
//  channel | role   | carries
//  req     | sink   | one vertex per beat: index, position, texcoord
//  rsp     | source | one corner result per beat, last on the third
// first two corners are taken one per cycle; the third enters a three-stage
// delta/product pipeline and a two-entry queue. the back end runs one shared
// restoring divider bit-serially; at default widths each component is a load,
// 57 quotient steps and a store, six components per triangle, then the three
// result beats. a zero determinant skips the divider. reset clears control state
// only (valids, counters, queue, FSM); either side may stall, the queue decouples them.
module triangle_tangent_bitangent #(
   parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEFAULT,
   parameter int COORD_BITS = ttb_pkg::COORD_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   ttb_req_if.sink  req,
   ttb_rsp_if.source rsp
);
   localparam int NUM_W = 2 * COORD_BITS + 4;
   localparam int TRI_W = 3 * INDEX_BITS + 7 * NUM_W;
   logic q_valid, q_ready;
   logic [TRI_W-1:0] q_data;

   ttb_front #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS), .NUM_W(NUM_W),
      .TRI_W(TRI_W)) u_front (.clock, .reset, .req, .q_valid, .q_ready, .q_data);
   ttb_back #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS), .NUM_W(NUM_W),
      .TRI_W(TRI_W)) u_back (.clock, .reset, .q_valid, .q_ready, .q_data, .rsp);
endmodule

[sv/ttb_checker.sv]
// port-level checks for the tangent unit, bound to the top level
module ttb_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last,
   input logic rsp_degenerate,
   input logic [31:0] rsp_tangent_x
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp valid dropped");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent_x == 32'd0)
      else $error("degenerate result not zero");
   a_flag_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_degenerate))
      else $error("triangle results not contiguous");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last(rsp.last), .rsp_degenerate(rsp.degenerate), .rsp_tangent_x(rsp.tangent_x));
